// ----- rtl/wvae_pkg.sv -----
// ----------------------------------------------------------------------------
// wvae_pkg
// Types, widths and constants shared by the velocity/acceleration estimator.
// ----------------------------------------------------------------------------
package wvae_pkg;

   localparam int POS_BITS       = 24;
   localparam int STAMP_BITS     = 40;
   localparam int VAL_BITS       = 32;
   localparam int CNT_BITS       = 2;
   localparam int AGE_BITS       = 32;
   localparam int DT_BITS        = STAMP_BITS + 1;
   localparam int NUM_BITS       = VAL_BITS + 2;
   localparam int SCALE_BITS     = 20;
   localparam int SCALE_IDX_BITS = $clog2(SCALE_BITS);
   localparam int PROD_BITS      = NUM_BITS + SCALE_BITS;
   localparam int ITER_BITS      = $clog2(PROD_BITS);
   localparam int WIN_DEPTH      = 3;
   localparam int AXES           = 3;

   // Microseconds per second.
   localparam logic [SCALE_BITS-1:0] SCALE     = 20'd1000000;
   localparam logic [AGE_BITS-1:0]   AGE_RESET = 32'd1000000;

   typedef logic signed [POS_BITS-1:0] pos_type;
   typedef logic [STAMP_BITS-1:0]      stamp_type;
   typedef logic signed [DT_BITS-1:0]  dt_type;
   typedef logic signed [NUM_BITS-1:0] num_type;
   typedef logic signed [VAL_BITS-1:0] val_type;
   typedef logic [CNT_BITS-1:0]        cnt_type;

   typedef struct packed {
      logic      start;
      num_type   num;
      stamp_type dt;
   } rate_req_type;

   typedef struct packed {
      logic    done;
      val_type value;
   } rate_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_AGE,
      S_EVAL,
      S_ISSUE,
      S_WAIT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      R_IDLE,
      R_MUL,
      R_DIV,
      R_FIN
   } rate_state_type;

endpackage

// ----- rtl/wvae_if.sv -----
// ----------------------------------------------------------------------------
// wvae request and response channels
// Valid/ready channels carrying sample transactions and estimate transactions.
// ----------------------------------------------------------------------------
interface wvae_req_if import wvae_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      func;
   pos_type   pos_x;
   pos_type   pos_y;
   pos_type   pos_z;
   stamp_type stamp_us;

   modport source (output valid, func, pos_x, pos_y, pos_z, stamp_us, input ready);
   modport sink   (input valid, func, pos_x, pos_y, pos_z, stamp_us, output ready);
endinterface

interface wvae_rsp_if import wvae_pkg::*; ();
   logic    valid;
   logic    ready;
   cnt_type kept_count;
   val_type vel_x;
   val_type vel_y;
   val_type vel_z;
   val_type acc_x;
   val_type acc_y;
   val_type acc_z;
   logic    model_ready;
   logic    interval_fault;

   modport source (output valid, kept_count, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z,
                   model_ready, interval_fault, input ready);
   modport sink   (input valid, kept_count, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z,
                   model_ready, interval_fault, output ready);
endinterface

// ----- rtl/wvae_rate.sv -----
// ----------------------------------------------------------------------------
// wvae_rate
// Bit-serial rate unit: sat32(trunc(num * 1e6 / dt)) for a positive dt.
// ----------------------------------------------------------------------------
module wvae_rate import wvae_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  rate_req_type req,
   output rate_rsp_type rsp
);

   rate_state_type            state_ff, state_in;
   logic                      neg_ff, neg_in;
   logic [NUM_BITS-1:0]       mag_ff, mag_in;
   logic [PROD_BITS-1:0]      acc_ff, acc_in;
   stamp_type                 rem_ff, rem_in;
   stamp_type                 dt_ff, dt_in;
   logic [ITER_BITS-1:0]      cnt_ff, cnt_in;
   logic                      done;
   val_type                   sat_value;

   logic [STAMP_BITS:0]       trial;
   logic [STAMP_BITS:0]       diff;
   logic                      ge;
   logic                      pos_over;
   logic                      neg_over;

   assign trial    = {rem_ff, acc_ff[PROD_BITS-1]};
   assign diff     = trial - {1'b0, dt_ff};
   assign ge       = trial >= {1'b0, dt_ff};
   assign pos_over = |acc_ff[PROD_BITS-1:VAL_BITS-1];
   assign neg_over = (|acc_ff[PROD_BITS-1:VAL_BITS])
                     || (acc_ff[VAL_BITS-1] && (|acc_ff[VAL_BITS-2:0]));

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      dt_in    = dt_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      unique case (state_ff)
         R_IDLE: begin
            if (req.start) begin
               neg_in   = req.num[NUM_BITS-1];
               mag_in   = req.num[NUM_BITS-1] ? (~req.num + 1'b1) : req.num;
               acc_in   = '0;
               dt_in    = req.dt;
               cnt_in   = ITER_BITS'(SCALE_BITS - 1);
               state_in = R_MUL;
            end
         end
         R_MUL: begin
            // Shift-add over the bits of the constant scale, MSB first.
            acc_in = {acc_ff[PROD_BITS-2:0], 1'b0}
                     + (SCALE[cnt_ff[SCALE_IDX_BITS-1:0]] ? PROD_BITS'(mag_ff)
                                                          : PROD_BITS'(0));
            if (cnt_ff == '0) begin
               cnt_in   = ITER_BITS'(PROD_BITS - 1);
               rem_in   = '0;
               state_in = R_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         R_DIV: begin
            // Restoring division; quotient bits shift into the product register.
            rem_in = ge ? diff[STAMP_BITS-1:0] : trial[STAMP_BITS-1:0];
            acc_in = {acc_ff[PROD_BITS-2:0], ge};
            if (cnt_ff == '0) begin
               state_in = R_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         R_FIN: begin
            done     = 1'b1;
            state_in = R_IDLE;
         end
         default: state_in = R_IDLE;
      endcase
   end

   // The quotient is complete in the product register during the final cycle.
   always_comb begin
      if (neg_ff) begin
         sat_value = neg_over ? val_type'({1'b1, {(VAL_BITS-1){1'b0}}})
                              : val_type'(~acc_ff[VAL_BITS-1:0] + 1'b1);
      end else begin
         sat_value = pos_over ? val_type'({1'b0, {(VAL_BITS-1){1'b1}}})
                              : val_type'(acc_ff[VAL_BITS-1:0]);
      end
   end

   assign rsp = '{done: done, value: sat_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
      end else begin
         state_ff <= state_in;
      end
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      dt_ff    <= dt_in;
      cnt_ff   <= cnt_in;
   end

endmodule

// ----- rtl/windowed_velocity_acceleration_estimator.sv -----
// ----------------------------------------------------------------------------
// windowed_velocity_acceleration_estimator
// Finite-difference velocity and acceleration over a three-sample window.
// ----------------------------------------------------------------------------
// The req_ch channel takes one transaction per sample (func 0) or a clear
// (func 1). Each request produces exactly one transaction on rsp_ch carrying
// the window fill, the held velocity and acceleration, the sticky model-ready
// flag and the interval fault flag. csr_wr_en/csr_wr_data write the age limit.
// One request is in work at a time. Every quotient runs through a bit-serial
// rate unit: an issue state, a shift-add step per bit of the 20-bit 1e6 scale,
// a restoring division step per bit of the 54-bit product and a saturate
// state. With three samples kept and no interval fault nine quotients run in
// series, three per axis; with two kept, one per axis; with one kept, or a
// clear, none. The age check drops at most two samples, one per cycle.
// Results sit in an output register, so a stalled receiver holds only that
// register; a new request is taken while it waits, and the next result waits
// until it has been taken. Synchronous reset empties the window, clears the
// estimates and flags and loads the age limit with one second.
// ----------------------------------------------------------------------------
module windowed_velocity_acceleration_estimator import wvae_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   wvae_req_if.sink            req_ch,
   wvae_rsp_if.source          rsp_ch,
   input  logic                csr_wr_en,
   input  logic [AGE_BITS-1:0] csr_wr_data
);

   typedef pos_type   pos_arr_type   [WIN_DEPTH][AXES];
   typedef stamp_type stamp_arr_type [WIN_DEPTH];
   typedef val_type   val_arr_type   [AXES];

   state_type           state_ff, state_in;
   pos_arr_type         pos_ff, pos_in;
   stamp_arr_type       stamp_ff, stamp_in;
   stamp_type           now_ff, now_in;
   cnt_type             fill_ff, fill_in;
   val_arr_type         vel_ff, vel_in;
   val_arr_type         acc_ff, acc_in;
   logic                ready_ff, ready_in;
   logic                fault_ff, fault_in;
   logic [AGE_BITS-1:0] limit_ff;
   logic [1:0]          step_ff, step_in;
   logic [1:0]          axis_ff, axis_in;
   dt_type              dtn_ff, dtn_in;
   dt_type              dto_ff, dto_in;
   val_type             vn_ff, vn_in;
   val_type             vo_ff, vo_in;

   logic                rsp_valid_ff, rsp_valid_in;
   cnt_type             out_count_ff;
   val_arr_type         out_vel_ff;
   val_arr_type         out_acc_ff;
   logic                out_ready_ff;
   logic                out_fault_ff;
   logic                out_load;

   rate_req_type        rate_req;
   rate_rsp_type        rate_rsp;

   dt_type              age;
   dt_type              dt_new;
   dt_type              dt_old;
   logic                full;

   wvae_rate u_rate (
      .clock (clock),
      .reset (reset),
      .req   (rate_req),
      .rsp   (rate_rsp)
   );

   assign full   = fill_ff == cnt_type'(WIN_DEPTH);
   assign age    = dt_type'({1'b0, now_ff}) - dt_type'({1'b0, stamp_ff[0]});
   assign dt_new = dt_type'({1'b0, stamp_ff[2]}) - dt_type'({1'b0, stamp_ff[1]});
   assign dt_old = dt_type'({1'b0, stamp_ff[1]}) - dt_type'({1'b0, stamp_ff[0]});

   assign req_ch.ready = state_ff == S_IDLE;

   // Operand selection for the rate unit; axis 0 of the window is current.
   always_comb begin
      rate_req.start = state_ff == S_ISSUE;
      if (full && step_ff == 2'd0) begin
         rate_req.num = num_type'(pos_ff[2][0]) - num_type'(pos_ff[1][0]);
         rate_req.dt  = dtn_ff[STAMP_BITS-1:0];
      end else if (full && step_ff == 2'd2) begin
         rate_req.num = num_type'(vn_ff) - num_type'(vo_ff);
         rate_req.dt  = dtn_ff[STAMP_BITS-1:0];
      end else begin
         rate_req.num = num_type'(pos_ff[1][0]) - num_type'(pos_ff[0][0]);
         rate_req.dt  = dto_ff[STAMP_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      stamp_in = stamp_ff;
      now_in   = now_ff;
      fill_in  = fill_ff;
      vel_in   = vel_ff;
      acc_in   = acc_ff;
      ready_in = ready_ff;
      fault_in = fault_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      dtn_in   = dtn_ff;
      dto_in   = dto_ff;
      vn_in    = vn_ff;
      vo_in    = vo_ff;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               fault_in = 1'b0;
               if (req_ch.func) begin
                  for (int s = 0; s < WIN_DEPTH; s++) begin
                     for (int a = 0; a < AXES; a++) begin
                        pos_in[s][a] = '0;
                     end
                     stamp_in[s] = '0;
                  end
                  for (int a = 0; a < AXES; a++) begin
                     vel_in[a] = '0;
                     acc_in[a] = '0;
                  end
                  fill_in  = '0;
                  ready_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  if (full) begin
                     for (int s = 0; s < WIN_DEPTH - 1; s++) begin
                        pos_in[s]   = pos_ff[s+1];
                        stamp_in[s] = stamp_ff[s+1];
                     end
                     pos_in[WIN_DEPTH-1][0]  = req_ch.pos_x;
                     pos_in[WIN_DEPTH-1][1]  = req_ch.pos_y;
                     pos_in[WIN_DEPTH-1][2]  = req_ch.pos_z;
                     stamp_in[WIN_DEPTH-1]   = req_ch.stamp_us;
                  end else begin
                     for (int s = 0; s < WIN_DEPTH; s++) begin
                        if (fill_ff == cnt_type'(s)) begin
                           pos_in[s][0] = req_ch.pos_x;
                           pos_in[s][1] = req_ch.pos_y;
                           pos_in[s][2] = req_ch.pos_z;
                           stamp_in[s]  = req_ch.stamp_us;
                        end
                     end
                     fill_in = fill_ff + 1'b1;
                  end
                  now_in   = req_ch.stamp_us;
                  state_in = S_AGE;
               end
            end
         end
         S_AGE: begin
            // The newest sample has age zero, so the window never empties here.
            if (age > dt_type'({1'b0, limit_ff})) begin
               for (int s = 0; s < WIN_DEPTH - 1; s++) begin
                  pos_in[s]   = pos_ff[s+1];
                  stamp_in[s] = stamp_ff[s+1];
               end
               fill_in = fill_ff - 1'b1;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            dtn_in  = dt_new;
            dto_in  = dt_old;
            step_in = 2'd0;
            axis_in = 2'd0;
            if (full) begin
               ready_in = 1'b1;
               if (dt_new <= 0 || dt_old <= 0) begin
                  fault_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_ISSUE;
               end
            end else if (fill_ff == 2'd2) begin
               if (dt_old <= 0) begin
                  fault_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_ISSUE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (rate_rsp.done) begin
               if (full && step_ff == 2'd0) begin
                  vn_in    = rate_rsp.value;
                  step_in  = 2'd1;
                  state_in = S_ISSUE;
               end else if (full && step_ff == 2'd1) begin
                  vo_in    = rate_rsp.value;
                  step_in  = 2'd2;
                  state_in = S_ISSUE;
               end else begin
                  // Axis finished: rotate window and estimates by one axis.
                  for (int s = 0; s < WIN_DEPTH; s++) begin
                     pos_in[s][0] = pos_ff[s][1];
                     pos_in[s][1] = pos_ff[s][2];
                     pos_in[s][2] = pos_ff[s][0];
                  end
                  vel_in[0] = vel_ff[1];
                  vel_in[1] = vel_ff[2];
                  acc_in[0] = acc_ff[1];
                  acc_in[1] = acc_ff[2];
                  if (full) begin
                     vel_in[2] = vn_ff;
                     acc_in[2] = rate_rsp.value;
                  end else begin
                     vel_in[2] = rate_rsp.value;
                     acc_in[2] = acc_ff[0];
                  end
                  step_in = 2'd0;
                  if (axis_ff == 2'(AXES - 1)) begin
                     state_in = S_DONE;
                  end else begin
                     axis_in  = axis_ff + 1'b1;
                     state_in = S_ISSUE;
                  end
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         ready_ff     <= 1'b0;
         fault_ff     <= 1'b0;
         limit_ff     <= AGE_RESET;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
         axis_ff      <= 2'd0;
         for (int s = 0; s < WIN_DEPTH; s++) begin
            for (int a = 0; a < AXES; a++) begin
               pos_ff[s][a] <= '0;
            end
            stamp_ff[s] <= '0;
         end
         for (int a = 0; a < AXES; a++) begin
            vel_ff[a] <= '0;
            acc_ff[a] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ready_ff     <= ready_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         pos_ff       <= pos_in;
         stamp_ff     <= stamp_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
      now_ff <= now_in;
      dtn_ff <= dtn_in;
      dto_ff <= dto_in;
      vn_ff  <= vn_in;
      vo_ff  <= vo_in;
      if (out_load) begin
         out_count_ff <= fill_ff;
         out_vel_ff   <= vel_ff;
         out_acc_ff   <= acc_ff;
         out_ready_ff <= ready_ff;
         out_fault_ff <= fault_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.kept_count     = out_count_ff;
   assign rsp_ch.vel_x          = out_vel_ff[0];
   assign rsp_ch.vel_y          = out_vel_ff[1];
   assign rsp_ch.vel_z          = out_vel_ff[2];
   assign rsp_ch.acc_x          = out_acc_ff[0];
   assign rsp_ch.acc_y          = out_acc_ff[1];
   assign rsp_ch.acc_z          = out_acc_ff[2];
   assign rsp_ch.model_ready    = out_ready_ff;
   assign rsp_ch.interval_fault = out_fault_ff;

endmodule
